>>> sv/syndec_pkg.sv
// Shared types, constants and codes for the SEC-DED syndrome decoder.
package syndec_pkg;

  localparam int CODE_BITS     = 288;
  localparam int SYN_BITS      = 16;
  localparam int CHUNK_BITS    = 32;
  localparam int LANES         = 4;   // power of two
  localparam int LANE_W        = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int BANK_DEPTH    = (CODE_BITS + LANES - 1) / LANES;
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int NUM_CHUNKS    = (CODE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CNT_W         = $clog2(NUM_CHUNKS + 1);
  localparam int STEPS         = (CHUNK_BITS + LANES - 1) / LANES;
  localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int POS_W         = $clog2(NUM_CHUNKS * CHUNK_BITS + 2 * LANES);
  localparam int CIDX_W        = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHUNK = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FIXED   = 2'd1;
  localparam logic [1:0] ST_UNCORR  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [8:0]  column_index;
    logic [15:0] column_value;
    logic [31:0] chunk_bits;
    logic        last_chunk;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  error_position;
    logic [15:0] syndrome;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic                we;
    logic [BANK_AW-1:0]  addr;
    logic [SYN_BITS-1:0] wdata;
    logic                take;   // xor read column into syndrome
    logic                cmp;    // compare read column with syndrome
  } lane_ctl_t;

  typedef struct packed {
    logic [SYN_BITS-1:0] contrib;
    logic                match;
  } lane_res_t;

  typedef struct packed {
    logic [SYN_BITS-1:0] xor_v;
    logic                any_match;
    logic [LANE_W-1:0]   lane_idx;
  } merge_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_DRAIN, S_SEARCH, S_RESULT
  } state_e;

endpackage

>>> sv/syndec_ram.sv
// Generic single-port RAM with registered read.
module syndec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 72
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/syndec_lane.sv
// One lane: a bank of H columns plus its xor and compare logic.
module syndec_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  syndec_pkg::lane_ctl_t         ctl_i,
  input  logic [syndec_pkg::SYN_BITS-1:0] syn_i,
  output syndec_pkg::lane_res_t         res_o
);
  import syndec_pkg::*;

  logic [SYN_BITS-1:0] rdata;
  logic                take_q, cmp_q;

  syndec_ram #(.WIDTH(SYN_BITS), .DEPTH(BANK_DEPTH)) u_bank (
    .clk_i  (clk_i),
    .en_i   (ctl_i.en),
    .we_i   (ctl_i.we),
    .addr_i (ctl_i.addr),
    .wdata_i(ctl_i.wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q <= 1'b0;
      cmp_q  <= 1'b0;
    end else begin
      take_q <= ctl_i.en && !ctl_i.we && ctl_i.take;
      cmp_q  <= ctl_i.en && !ctl_i.we && ctl_i.cmp;
    end
  end

  assign res_o.contrib = take_q ? rdata : '0;
  assign res_o.match   = cmp_q && (rdata == syn_i);
endmodule

>>> sv/syndec_merge.sv
// Combines lane results: xor of contributions, lowest matching lane.
module syndec_merge (
  input  syndec_pkg::lane_res_t res_i [syndec_pkg::LANES],
  output syndec_pkg::merge_t    merge_o
);
  import syndec_pkg::*;

  always_comb begin
    merge_o = '0;
    for (int b = LANES - 1; b >= 0; b--) begin
      merge_o.xor_v = merge_o.xor_v ^ res_i[b].contrib;
      if (res_i[b].match) begin
        merge_o.any_match = 1'b1;
        merge_o.lane_idx  = LANE_W'(b);
      end
    end
  end
endmodule

>>> sv/syndrome_secded_decoder_top.sv
// Top level of the SEC-DED syndrome decoder with loadable H matrix.
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes two kinds of
// transfer: a load writes one 16-bit H column, a chunk carries 32 code
// bits. Output channel (out_valid_o/out_ready_i/out_item_o) gives one
// result per chunk marked last_chunk.
// H columns live in LANES single-port banks, column p in bank p%LANES.
// Sequencing per transfer:
//   load: taken in IDLE, back to back.
//   chunk: an accept, then the read steps (one column read per lane per
//     cycle), then a drain.
//   chunk past the codeword length: taken without any column read.
//   last chunk adds a match search: a zero syndrome gives no-error directly,
//     else one bank row is read per cycle, stopping at the first match;
//     then the RESULT state loads the output register.
// The result sits in an output register; if the receiver stalls, the
// block holds the next result in its RESULT state and takes no input
// until the output register frees up. Loads may still arrive while a
// result waits in the output register.
// Reset clears the syndrome, chunk count and handshake state; H columns
// are undefined until loaded.
module syndrome_secded_decoder_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  syndec_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output syndec_pkg::out_item_t out_item_o
);
  import syndec_pkg::*;

  state_e state_q, state_d;

  logic [SYN_BITS-1:0]   syn_q, syn_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [POS_W-1:0]      base_q, base_d;
  logic [CHUNK_BITS-1:0] bits_q, bits_d;
  logic                  last_q, last_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [BANK_AW:0]      row_q, row_d;       // next row to issue
  logic [BANK_AW-1:0]    cmp_row_q, cmp_row_d;
  logic                  issued_q, issued_d;
  logic [1:0]            res_st_q, res_st_d;
  logic [8:0]            res_pos_q, res_pos_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  lane_ctl_t ctl [LANES];
  lane_res_t res [LANES];
  merge_t    mrg;

  logic in_fire, load_fire, chunk_fire, out_free, issuing;
  logic [POS_W-1:0] start_w;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_fire   = in_fire && (in_item_i.command == CMD_LOAD)
                       && (int'(in_item_i.column_index) < CODE_BITS);
  assign chunk_fire  = in_fire && (in_item_i.command == CMD_CHUNK);
  assign out_free    = !out_valid_q || out_ready_i;
  assign issuing     = (state_q == S_SEARCH) && !mrg.any_match
                       && (int'(row_q) < BANK_DEPTH);
  assign start_w     = base_q + POS_W'(step_q) * POS_W'(LANES);

  // Per-lane control: load write, chunk accumulate read, search read.
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [LANE_W-1:0] off;
    logic [POS_W-1:0]  pos, idx, spos;
    assign off  = LANE_W'(b) - start_w[LANE_W-1:0];
    assign pos  = start_w + POS_W'(off);
    assign idx  = pos - base_q;
    assign spos = POS_W'(row_q) * POS_W'(LANES) + POS_W'(b);

    always_comb begin
      ctl[b] = '0;
      ctl[b].wdata = in_item_i.column_value[SYN_BITS-1:0];
      if (state_q == S_IDLE) begin
        ctl[b].en   = load_fire && (in_item_i.column_index[LANE_W-1:0] == LANE_W'(b));
        ctl[b].we   = 1'b1;
        ctl[b].addr = BANK_AW'(in_item_i.column_index >> LANE_W);
      end else if (state_q == S_ACC) begin
        ctl[b].take = (int'(idx) < CHUNK_BITS) && (int'(pos) < CODE_BITS)
                      && bits_q[idx[CIDX_W-1:0]];
        ctl[b].en   = ctl[b].take;
        ctl[b].addr = BANK_AW'(pos >> LANE_W);
      end else if (state_q == S_SEARCH) begin
        ctl[b].cmp  = issuing && (int'(spos) < CODE_BITS);
        ctl[b].en   = ctl[b].cmp;
        ctl[b].addr = row_q[BANK_AW-1:0];
      end
    end

    syndec_lane u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl[b]),
      .syn_i (syn_q),
      .res_o (res[b])
    );
  end

  syndec_merge u_merge (
    .res_i  (res),
    .merge_o(mrg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      syn_q       <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      row_q       <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      syn_q       <= syn_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      row_q       <= row_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    bits_q    <= bits_d;
    last_q    <= last_d;
    cmp_row_q <= cmp_row_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    out_q     <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    syn_d       = syn_q ^ mrg.xor_v;
    cnt_d       = cnt_q;
    base_d      = base_q;
    bits_d      = bits_q;
    last_d      = last_q;
    step_d      = step_q;
    row_d       = row_q;
    cmp_row_d   = cmp_row_q;
    issued_d    = 1'b0;
    res_st_d    = res_st_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (chunk_fire) begin
          bits_d = in_item_i.chunk_bits[CHUNK_BITS-1:0];
          last_d = in_item_i.last_chunk;
          base_d = POS_W'(cnt_q) * POS_W'(CHUNK_BITS);
          step_d = '0;
          row_d  = '0;
          if (int'(cnt_q) < NUM_CHUNKS) begin
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = S_ACC;
          end else if (in_item_i.last_chunk) begin
            state_d = S_SEARCH;
          end
        end
      end
      S_ACC: begin
        step_d = step_q + STEP_W'(1);
        if (int'(step_q) == STEPS - 1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = last_q ? S_SEARCH : S_IDLE;
      end
      S_SEARCH: begin
        if (syn_q == '0) begin
          res_st_d  = ST_OK;
          res_pos_d = '0;
          state_d   = S_RESULT;
        end else if (mrg.any_match) begin
          res_st_d  = ST_FIXED;
          res_pos_d = 9'(POS_W'(cmp_row_q) * POS_W'(LANES) + POS_W'(mrg.lane_idx));
          state_d   = S_RESULT;
        end else if (issuing) begin
          row_d     = row_q + (BANK_AW+1)'(1);
          cmp_row_d = row_q[BANK_AW-1:0];
          issued_d  = 1'b1;
        end else if (!issued_q) begin
          res_st_d  = ST_UNCORR;
          res_pos_d = '0;
          state_d   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.status         = res_st_q;
          out_d.error_position = res_pos_q;
          out_d.syndrome       = syn_q;
          syn_d                = '0;
          cnt_d                = '0;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= NUM_CHUNKS) else $error("chunk count past codeword");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status != 2'd3)) else $error("bad status");
  a_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_OK) |-> (out_item_o.syndrome == '0))
    else $error("no-error result with nonzero syndrome");
endmodule

>>> dv/tb.sv
// Self-checking testbench for the SEC-DED syndrome decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import syndec_pkg::*;

  // Expected-result store plus a private copy of the H matrix and syndrome.
  class decode_scoreboard;
    logic [15:0] h_cols [CODE_BITS];
    logic [15:0] acc_syn;
    int unsigned chunks_seen;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      acc_syn = '0;
      chunks_seen = 0;
      errors = 0;
      foreach (h_cols[p]) h_cols[p] = '0;
    endfunction

    // Update the private state for one accepted input transfer.
    function void note_input(in_item_t it);
      out_item_t r;
      int unsigned pos;
      if (it.command == CMD_LOAD) begin
        if (it.column_index < CODE_BITS) h_cols[it.column_index] = it.column_value;
        return;
      end
      if (chunks_seen < NUM_CHUNKS) begin
        for (int i = 0; i < CHUNK_BITS; i++) begin
          pos = chunks_seen * CHUNK_BITS + i;
          if (pos < CODE_BITS && it.chunk_bits[i]) acc_syn ^= h_cols[pos];
        end
        chunks_seen++;
      end
      if (!it.last_chunk) return;
      r.status = ST_OK;
      r.error_position = '0;
      r.syndrome = acc_syn;
      if (acc_syn != 0) begin
        r.status = ST_UNCORR;
        for (int p = 0; p < CODE_BITS; p++)
          if (h_cols[p] == acc_syn) begin
            r.status = ST_FIXED;
            r.error_position = p[8:0];
            break;
          end
      end
      pending_q.push_back(r);
      acc_syn = '0;
      chunks_seen = 0;
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.error_position !== want.error_position) begin
        $display("%0t: position exp %0d got %0d", $realtime,
                 want.error_position, got.error_position);
        errors++;
      end
      if (got.syndrome !== want.syndrome) begin
        $display("%0t: syndrome exp %h got %h", $realtime, want.syndrome, got.syndrome);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  decode_scoreboard sb = new();
  bit     stim_done = 1'b0;
  bit     long_stall = 1'b0;    // receiver holds off while set
  int     idle_cycles = 0;

  localparam int IdleLimit = 20000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  syndrome_secded_decoder_top dut (.*);

  // Track transfers on both channels; watchdog counts cycles without one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  always @(posedge clk_i) begin
    int unsigned mode;
    mode = 32'(($time / 3000) % 3);
    if (long_stall) out_ready_i <= 1'b0;
    else if (mode == 0) out_ready_i <= 1'b1;
    else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= ($urandom_range(0, 4) == 0);
  end

  // Offer one transfer and hold it until accepted.
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic load_column(int unsigned idx, logic [15:0] val, bit last = 0);
    in_item_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.column_index = idx[8:0];
    it.column_value = val;
    it.chunk_bits = $urandom();
    it.last_chunk = last;
    send_item(it);
  endtask

  task automatic send_chunk(logic [31:0] bits, bit last);
    in_item_t it;
    it = '0;
    it.command = CMD_CHUNK;
    it.column_index = 9'($urandom());
    it.column_value = 16'($urandom());
    it.chunk_bits = bits;
    it.last_chunk = last;
    send_item(it);
  endtask

  // Build a codeword from all-zero data; flip 0, 1 or 2 bits or inject random noise.
  task automatic send_codeword(int unsigned nchunks, int unsigned kind);
    logic [31:0] w [16];
    int unsigned b;
    for (int k = 0; k < 16; k++) w[k] = (kind == 3) ? $urandom() : '0;
    if (kind == 1 || kind == 2) begin
      b = $urandom_range(0, CODE_BITS - 1);
      w[b / 32][b % 32] = 1'b1;
    end
    if (kind == 2) begin
      b = $urandom_range(0, CODE_BITS - 1);
      w[b / 32][b % 32] ^= 1'b1;
    end
    for (int k = 0; k < nchunks; k++) begin
      send_chunk(w[k], k == nchunks - 1);
      if ($urandom_range(0, 4) == 0) sender_gap();
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] v;
    int unsigned burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Distinct odd-valued columns, all written once.
    for (int p = 0; p < CODE_BITS; p++) begin
      v = 16'h0007 + 16'(p * 2);
      if (p == 0) v = 16'h0001;
      if (p == CODE_BITS - 1) v = 16'hFFFF;
      load_column(p, v, p[0]);
    end
    load_column(511, 16'hFFFF);          // out-of-range index, ignored
    load_column(300, 16'h1234);

    // Directed: all-zero word, single flips at ends, double error, extremes.
    send_codeword(9, 0);
    send_chunk(32'h0000_0001, 1'b1);                // corrected bit 0
    for (int k = 0; k < 8; k++) send_chunk('0, 1'b0);
    send_chunk(32'h8000_0000, 1'b1);                // corrected bit 287
    send_chunk(32'hFFFF_FFFF, 1'b0);
    send_chunk(32'hFFFF_FFFF, 1'b1);                // ends early
    for (int k = 0; k < 11; k++) send_chunk(32'hFFFF_FFFF, k == 10); // extra chunks
    send_codeword(9, 2);
    wait_drained();
    load_column(5, 16'h0001);                       // duplicate column: lowest wins
    send_chunk(32'h0000_0020, 1'b1);
    load_column(5, 16'h0011);

    // Long receiver hold-off while the sender keeps offering.
    long_stall = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        long_stall = 1'b0;
      end
      for (int n = 0; n < 6; n++) send_codeword(1, 3);
    join
    wait_drained();

    // Random part: mostly full codewords, some short/long ones and reloads.
    for (int n = 0; n < 8; n++) begin
      burst = $urandom_range(1, 4);
      for (int j = 0; j < burst; j++) begin
        case ($urandom_range(0, 9))
          0: load_column($urandom_range(0, 511), 16'($urandom()), $urandom_range(0, 1));
          1: send_codeword($urandom_range(1, 12), $urandom_range(0, 3));
          default: send_codeword(9, $urandom_range(0, 3));
        endcase
      end
      sender_gap();
      if (n == 4) wait_drained();
    end

    wait_drained();
    stim_done = 1'b1;
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
